### rtl/gdad_pkg.sv
package gdad_pkg;

	localparam int YEAR_BITS_DEF = 14;
	localparam int ADD_BITS_DEF  = 16;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int STATUS_W = 2;

	// Year modulo 400 fits in nine bits
	localparam int R400_W = 9;
	localparam logic [R400_W-1:0] R400_LAST = R400_W'(399);

	localparam int DAYS_PER_400 = 146097;
	localparam int YEARS_STEP   = 400;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	// Leap test from year mod 400: divisible by 4, not by 100, unless by 400
	function automatic logic is_leap(input logic [R400_W-1:0] r);
		logic cent;
		cent = (r == R400_W'(100)) || (r == R400_W'(200)) || (r == R400_W'(300));
		return (r[1:0] == 2'b00) && !cent;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = DAY_W'(31);
		if (m == MON_FEB) begin
			len = leap ? DAY_W'(29) : DAY_W'(28);
		end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
			len = DAY_W'(30);
		end
		return len;
	endfunction

endpackage

### rtl/gdad_mod400.sv
module gdad_mod400 #(
	parameter int YEAR_BITS = gdad_pkg::YEAR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [YEAR_BITS-1:0]          year,
	output logic                          done,
	output logic [gdad_pkg::R400_W-1:0]   rem
);
	import gdad_pkg::*;

	// Reciprocal of 400 scaled by 2^29; gives the exact quotient for years below 2^20
	localparam int RECIP_SHIFT = 29;
	localparam int RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(1342178);
	localparam int PROD_W = YEAR_BITS + RECIP_W;
	localparam int QUO_W  = PROD_W - RECIP_SHIFT;

	logic [YEAR_BITS-1:0] yr_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 mul_q;
	logic                 done_q;
	logic [PROD_W-1:0]    prod;
	logic [YEAR_BITS-1:0] back;
	logic [YEAR_BITS-1:0] diff;

	// Multiply the registered year by the reciprocal into the quotient register, then subtract the quotient times 400
	assign prod = PROD_W'(yr_q) * PROD_W'(RECIP_400);
	assign back = YEAR_BITS'(quo_q) * YEAR_BITS'(YEARS_STEP);
	assign diff = yr_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start;
			done_q <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			yr_q <= year;
		end
		if (mul_q) begin
			quo_q <= prod[PROD_W-1:RECIP_SHIFT];
		end
	end

	assign done = done_q;
	assign rem  = diff[R400_W-1:0];

endmodule

### rtl/gregorian_date_add_days.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// request  | in_valid / in_stall | start_day, start_month, start_year, days_to_add
// result   | out_valid/out_stall | end_day, end_month, end_year, status
//
// A request passes through accept, year mod 400, date check, 400-year skips,
// month steps, landing and finish; an invalid date goes from the check
// straight to finish.
// Reset clears the sequencer and the result valid flag; date registers hold.
// in_stall stays high from accept until the result is loaded into the output
// register; a request is taken while a finished result still waits downstream.
module gregorian_date_add_days #(
	parameter int YEAR_BITS = gdad_pkg::YEAR_BITS_DEF,
	parameter int ADD_BITS  = gdad_pkg::ADD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [gdad_pkg::DAY_W-1:0]     start_day,
	input  logic [gdad_pkg::MONTH_W-1:0]   start_month,
	input  logic [YEAR_BITS-1:0]           start_year,
	input  logic [ADD_BITS-1:0]            days_to_add,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gdad_pkg::DAY_W-1:0]     end_day,
	output logic [gdad_pkg::MONTH_W-1:0]   end_month,
	output logic [YEAR_BITS-1:0]           end_year,
	output logic [gdad_pkg::STATUS_W-1:0]  status
);
	import gdad_pkg::*;

	// Compare width wide enough for the 400-year day count
	localparam int LW = (ADD_BITS > 18) ? ADD_BITS : 18;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_CHECK,
		S_SKIP,
		S_WALK,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [DAY_W-1:0]      d_q;
	logic [MONTH_W-1:0]    m_q;
	logic [YEAR_BITS-1:0]  y_q;
	logic [ADD_BITS-1:0]   left_q;
	logic [R400_W-1:0]     r_q;
	logic [STATUS_W-1:0]   st_q;
	logic                  out_valid_q;
	logic [DAY_W-1:0]      end_day_q;
	logic [MONTH_W-1:0]    end_month_q;
	logic [YEAR_BITS-1:0]  end_year_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  accept;
	logic                  mod_done;
	logic [R400_W-1:0]     mod_rem;
	logic [DAY_W-1:0]      len;
	logic [DAY_W-1:0]      rem_days;
	logic [ADD_BITS-1:0]   step_days;
	logic                  month_bad;
	logic                  can_skip;
	logic                  out_free;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	gdad_mod400 #(
		.YEAR_BITS (YEAR_BITS)
	) u_mod400 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.year   (start_year),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// Shared month-length unit, fed from the working date
	assign len       = month_len(m_q, is_leap(r_q));
	assign rem_days  = len - d_q;
	assign step_days = ADD_BITS'(rem_days) + ADD_BITS'(1);
	assign month_bad = (m_q < MON_JAN) || (m_q > MON_DEC) || (d_q == '0) || (d_q > len);
	assign can_skip  = (LW'(left_q) >= LW'(DAYS_PER_400))
		&& ((YEAR_BITS+1)'(y_q) + (YEAR_BITS+1)'(YEARS_STEP) <= (YEAR_BITS+1)'(YEAR_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drop the valid flag once it is taken
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= month_bad ? S_FINISH : S_SKIP;
				end
				S_SKIP: begin
					if (!can_skip) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (left_q == '0 || left_q <= ADD_BITS'(rem_days)) begin
						state_q <= S_FINISH;
					end else if (m_q == MON_DEC && y_q == YEAR_MAX) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					d_q    <= start_day;
					m_q    <= start_month;
					y_q    <= start_year;
					left_q <= days_to_add;
					st_q   <= ST_OK;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					r_q <= mod_rem;
				end
			end
			S_CHECK: begin
				if (month_bad) begin
					st_q <= ST_INVALID;
				end
			end
			S_SKIP: begin
				// 400 years always span the same day count; year mod 400 holds
				if (can_skip) begin
					left_q <= left_q - ADD_BITS'(DAYS_PER_400);
					y_q    <= y_q + YEAR_BITS'(YEARS_STEP);
				end
			end
			S_WALK: begin
				if (left_q == '0) begin
					left_q <= '0;
				end else if (left_q <= ADD_BITS'(rem_days)) begin
					// Land inside this month
					d_q    <= d_q + left_q[DAY_W-1:0];
					left_q <= '0;
				end else if (m_q == MON_DEC) begin
					if (y_q == YEAR_MAX) begin
						st_q <= ST_OVERFLOW;
						d_q  <= DAY_W'(31);
						m_q  <= MON_DEC;
					end else begin
						left_q <= left_q - step_days;
						d_q    <= DAY_W'(1);
						m_q    <= MON_JAN;
						y_q    <= y_q + YEAR_BITS'(1);
						r_q    <= (r_q == R400_LAST) ? '0 : r_q + R400_W'(1);
					end
				end else begin
					// Advance to the first of the next month
					left_q <= left_q - step_days;
					d_q    <= DAY_W'(1);
					m_q    <= m_q + MONTH_W'(1);
				end
			end
			S_FINISH: begin
				if (out_free) begin
					end_day_q   <= d_q;
					end_month_q <= m_q;
					end_year_q  <= y_q;
					status_q    <= st_q;
				end
			end
			default: begin
				left_q <= left_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;
	assign status    = status_q;

endmodule

### tb/tb_gregorian_date_add_days.sv
module tb_gregorian_date_add_days;
	timeunit 1ns;
	timeprecision 1ps;

	import gdad_pkg::*;

	localparam int YEAR_BITS = YEAR_BITS_DEF;
	localparam int ADD_BITS  = ADD_BITS_DEF;
	localparam int unsigned YEAR_LAST = (1 << YEAR_BITS) - 1;
	localparam int unsigned DAYS_LAST = (1 << ADD_BITS) - 1;

	// One request can walk about 2155 months; the long receiver hold-off adds
	// its own stretch on top of that, so the watchdog leaves a wide margin.
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_CYCLES = 2500;
	localparam int IDLE_LIMIT   = 20000;
	localparam int RANDOM_ITEMS = 250;

	typedef struct packed {
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_BITS-1:0] year;
		logic [ADD_BITS-1:0] days;
	} date_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]     day;
		logic [MONTH_W-1:0]   month;
		logic [YEAR_BITS-1:0] year;
		logic [STATUS_W-1:0]  st;
	} date_result_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} stall_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [DAY_W-1:0]      start_day   = '0;
	logic [MONTH_W-1:0]    start_month = '0;
	logic [YEAR_BITS-1:0]  start_year  = '0;
	logic [ADD_BITS-1:0]   days_to_add = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [DAY_W-1:0]      end_day;
	logic [MONTH_W-1:0]    end_month;
	logic [YEAR_BITS-1:0]  end_year;
	logic [STATUS_W-1:0]   status;

	date_req_t    pending_q[$];
	date_result_t expected_q[$];

	int unsigned total_requests = 0;
	int unsigned req_count      = 0;
	int unsigned req_offered    = 0;
	int unsigned result_count   = 0;
	int unsigned mismatch_count = 0;

	int          burst_left = 1;
	int          gap_left   = 0;

	stall_mode_t rx_mode       = RX_FREE;
	int          rx_phase_left = 0;
	int unsigned rx_tick       = 0;
	int          hold_left     = 0;
	bit          hold_done     = 1'b0;

	int unsigned idle_cycles = 0;

	gregorian_date_add_days #(
		.YEAR_BITS(YEAR_BITS),
		.ADD_BITS (ADD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_day  (start_day),
		.start_month(start_month),
		.start_year (start_year),
		.days_to_add(days_to_add),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.end_day    (end_day),
		.end_month  (end_month),
		.end_year   (end_year),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gregorian leap rule: every fourth year, but not centuries unless the
	// century is a multiple of four hundred. Year zero counts as leap.
	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (m == MON_FEB)
			return leap ? 29 : 28;
		if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
			return 30;
		return 31;
	endfunction

	// Walk the start date forward a month at a time. Out-of-range start dates
	// pass through with the invalid flag; running past the last day of the
	// largest year clamps to 31 December of that year with the overflow flag.
	function automatic date_result_t predict_end_date(input date_req_t r);
		date_result_t res;
		int unsigned  d;
		int unsigned  m;
		int unsigned  y;
		int unsigned  left;
		int unsigned  len;
		d      = r.day;
		m      = r.month;
		y      = r.year;
		left   = r.days;
		res.st = ST_OK;
		if (m < MON_JAN || m > MON_DEC || d < 1 || d > days_in_month(y, m)) begin
			res.st = ST_INVALID;
		end else begin
			// whole 400-year cycles have a fixed length; skip them in one go
			while (left >= DAYS_PER_400 && y + YEARS_STEP <= YEAR_LAST) begin
				left -= DAYS_PER_400;
				y    += YEARS_STEP;
			end
			while (left > 0) begin
				len = days_in_month(y, m);
				if (left > len - d) begin
					left -= len - d + 1;
					d = 1;
					m++;
					if (m > MON_DEC) begin
						if (y >= YEAR_LAST) begin
							res.st = ST_OVERFLOW;
							d = 31;
							m = MON_DEC;
							y = YEAR_LAST;
							break;
						end
						m = MON_JAN;
						y++;
					end
				end else begin
					d += left;
					left = 0;
				end
			end
		end
		res.day   = d[DAY_W-1:0];
		res.month = m[MONTH_W-1:0];
		res.year  = y[YEAR_BITS-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic queue_request(input int unsigned d, input int unsigned m,
			input int unsigned y, input int unsigned n);
		date_req_t r;
		r.day   = d[DAY_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.year  = y[YEAR_BITS-1:0];
		r.days  = n[ADD_BITS-1:0];
		pending_q.push_back(r);
	endtask

	// Most requests step only a few months; a minority spans the full count.
	function automatic int unsigned pick_days();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom_range(0, 400);
		if (sel < 85)
			return $urandom_range(0, 4000);
		return $urandom_range(0, DAYS_LAST);
	endfunction

	function automatic int unsigned pick_year();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom_range(0, YEAR_LAST);
		if (sel < 80)
			return $urandom_range(YEAR_LAST - 383, YEAR_LAST);
		// century years and their neighbors exercise the leap exceptions
		return ($urandom_range(0, YEAR_LAST / 400) * 400 + $urandom_range(0, 3) * 100
			+ $urandom_range(0, 1)) % (YEAR_LAST + 1);
	endfunction

	// Driver: hold the request until it is taken, then offer the next one from
	// the pending queue. Bursts of random length alternate with random gaps.
	always @(negedge clk) begin
		if (arst_n && req_count == req_offered) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				start_day   <= pending_q[0].day;
				start_month <= pending_q[0].month;
				start_year  <= pending_q[0].year;
				days_to_add <= pending_q[0].days;
				void'(pending_q.pop_front());
				in_valid <= 1'b1;
				req_offered++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4, 5: gap_left = 0;
						17, 18, 19:       gap_left = $urandom_range(10, 40);
						default:          gap_left = $urandom_range(1, 5);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: switch between stall patterns after phases of random length. Once,
	// after the first results are through, hold off for a long stretch while
	// the driver keeps offering so the block fills and stalls its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && result_count >= 30) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (rx_phase_left <= 0) begin
				rx_mode       = stall_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(20, 300);
			end
			rx_phase_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE:     out_stall <= 1'b0;
				RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
				RX_PERIODIC: out_stall <= (rx_tick % 5 < 3);
				default:     out_stall <= ($urandom_range(0, 99) < 75);
			endcase
		end
	end

	// Monitor: check the result first, then predict the newly taken request,
	// so a result can never be matched against a request of the same edge.
	always @(posedge clk) begin
		date_result_t want;
		date_req_t    req;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d/%0d st=%0d with none pending",
						end_day, end_month, end_year, status));
				end else begin
					want = expected_q.pop_front();
					if (end_day !== want.day)
						report_mismatch($sformatf("end_day %0d, expected %0d",
							end_day, want.day));
					if (end_month !== want.month)
						report_mismatch($sformatf("end_month %0d, expected %0d",
							end_month, want.month));
					if (end_year !== want.year)
						report_mismatch($sformatf("end_year %0d, expected %0d",
							end_year, want.year));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.st));
				end
			end
			if (in_valid && !in_stall) begin
				req.day   = start_day;
				req.month = start_month;
				req.year  = start_year;
				req.days  = days_to_add;
				expected_q.push_back(predict_end_date(req));
				req_count++;
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned y;
		int unsigned m;
		// directed: zero days in year zero, leap and century Februaries
		queue_request(1, MON_JAN, 0, 0);
		queue_request(28, MON_FEB, 2000, 1);
		queue_request(28, MON_FEB, 1900, 1);
		queue_request(28, MON_FEB, 2024, 1);
		queue_request(29, MON_FEB, 0, 365);
		queue_request(31, MON_DEC, 2023, 1);
		queue_request(31, MON_JAN, 2001, 29);
		// directed: invalid start dates pass straight through
		queue_request(29, MON_FEB, 2023, 10);
		queue_request(29, MON_FEB, 1900, 0);
		queue_request(31, MON_APR, 2021, 5);
		queue_request(0, MON_JUN, 1999, 7);
		queue_request(1, 0, 1234, 100);
		queue_request(15, 13, 42, 9);
		queue_request(31, 15, YEAR_LAST, DAYS_LAST);
		queue_request(0, 0, 0, 0);
		// directed: the top of the year range, with and without overflow
		queue_request(31, MON_DEC, YEAR_LAST - 1, 1);
		queue_request(30, MON_NOV, YEAR_LAST, 31);
		queue_request(30, MON_NOV, YEAR_LAST, 32);
		queue_request(31, MON_DEC, YEAR_LAST, 1);
		queue_request(31, MON_DEC, YEAR_LAST, 0);
		queue_request(1, MON_JAN, YEAR_LAST, DAYS_LAST);
		// directed: full-range day counts
		queue_request(1, MON_JAN, 0, DAYS_LAST);
		queue_request(15, 3, 1999, DAYS_LAST);
		queue_request(31, MON_DEC, YEAR_LAST - 180, DAYS_LAST);

		// random: mostly well-formed dates, some raw field noise
		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				y = pick_year();
				m = $urandom_range(MON_JAN, MON_DEC);
				queue_request($urandom_range(1, days_in_month(y, m)), m, y, pick_days());
			end else begin
				queue_request($urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, YEAR_LAST), pick_days());
			end
		end
		total_requests = pending_q.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_count < total_requests || expected_q.size() != 0)
			@(posedge clk);
		// give a stray extra result time to show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
